/* hdl/bbcw_pkg.sv */
// ============================================================================
// bbcw_pkg: shared types and constants of the clipped-window box blur
// Configuration register layout, field widths and input kind codes.
// ============================================================================
package bbcw_pkg;

    // Field widths fixed by the pixel and register formats
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int RADIUS_W = 4;
    localparam int DIM_W    = 11;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
    localparam logic [DIM_W-1:0]    WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0]    HEIGHT_RST = 11'd1024;

    // Configuration as seen by the front end
    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
    } t_cfg;

endpackage

/* hdl/bbcw_queue.sv */
// ============================================================================
// bbcw_queue: two-entry job queue
// Decouples the classifying front end from the window back end.
// ============================================================================
module bbcw_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* hdl/bbcw_front.sv */
// ============================================================================
// bbcw_front: frame tracking and job classification
// Tracks input and output positions, takes the configuration at frame start
// and turns each beat into a job: an optional store write and an optional
// window to average.
// ============================================================================
module bbcw_front #(
    parameter  int MAX_WIDTH  = 1024,
    parameter  int MAX_HEIGHT = 1024,
    parameter  int MAX_RADIUS = 15,
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int HW    = $clog2(MAX_HEIGHT + 1),
    localparam int RW    = $clog2(MAX_RADIUS + 1),
    localparam int CW    = $clog2(2 * MAX_RADIUS + 2),
    localparam int RING  = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1),
    localparam int AW    = $clog2(RING),
    localparam int PW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS
                                  + MAX_WIDTH * MAX_HEIGHT + 1),
    localparam int JOB_W = 3 + 24 + 2 * AW + 2 * RW + 2 * CW + WW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bbcw_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [23:0]          i_pixel,
    output logic                 o_push,
    output logic [JOB_W-1:0]     o_job,
    input  logic                 i_full
);
    import bbcw_pkg::*;

    typedef struct packed {
        logic              wen;
        logic [PIX_W-1:0]  px;
        logic [AW-1:0]     wr_addr;
        logic              emit;
        logic              last;
        logic [AW-1:0]     out_addr;
        logic [RW-1:0]     yoff;
        logic [RW-1:0]     xoff;
        logic [CW-1:0]     rows;
        logic [CW-1:0]     cols;
        logic [WW-1:0]     w;
    } t_job;

    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_delay;
    logic [PW-1:0] r_area;
    logic [AW-1:0] r_wr_addr;
    logic [AW-1:0] r_out_addr;
    logic [HW-1:0] r_out_row;
    logic [WW-1:0] r_out_col;
    logic [RW-1:0] r_act_r;
    logic [WW-1:0] r_act_w;
    logic [HW-1:0] r_act_h;

    logic          first;
    logic          accept;
    logic [RW-1:0] sat_r;
    logic [WW-1:0] sat_w;
    logic [HW-1:0] sat_h;
    logic [RW-1:0] cur_r;
    logic [WW-1:0] cur_w;
    logic [HW-1:0] cur_h;
    logic          emit;
    logic          last;
    int            below_y;
    int            below_x;
    logic [RW-1:0] yoff;
    logic [RW-1:0] xoff;
    logic [RW-1:0] ylow;
    logic [RW-1:0] xlow;
    t_job          job;

    assign o_ready = ~i_full;
    assign accept  = i_valid & ~i_full;
    assign o_push  = accept;
    assign first   = (r_pos == '0);

    // Saturate the registers to the supported range
    always_comb begin
        sat_r = (int'(i_cfg.radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(i_cfg.radius);
        if (i_cfg.image_width == '0) begin
            sat_w = WW'(1);
        end else if (int'(i_cfg.image_width) > MAX_WIDTH) begin
            sat_w = WW'(MAX_WIDTH);
        end else begin
            sat_w = WW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            sat_h = HW'(1);
        end else if (int'(i_cfg.image_height) > MAX_HEIGHT) begin
            sat_h = HW'(MAX_HEIGHT);
        end else begin
            sat_h = HW'(i_cfg.image_height);
        end
    end

    // Classification of the current beat
    always_comb begin
        cur_r = first ? sat_r : r_act_r;
        cur_w = first ? sat_w : r_act_w;
        cur_h = first ? sat_h : r_act_h;
        emit  = first ? (sat_r == '0) : (r_pos >= r_delay);
        last  = emit && (r_out_row == cur_h - HW'(1)) && (r_out_col == cur_w - WW'(1));

        // Window extent around the output pixel, clipped to the frame
        yoff    = (int'(r_out_row) < int'(cur_r)) ? RW'(r_out_row) : cur_r;
        xoff    = (int'(r_out_col) < int'(cur_r)) ? RW'(r_out_col) : cur_r;
        below_y = int'(cur_h) - 1 - int'(r_out_row);
        below_x = int'(cur_w) - 1 - int'(r_out_col);
        ylow    = (below_y < int'(cur_r)) ? RW'(below_y) : cur_r;
        xlow    = (below_x < int'(cur_r)) ? RW'(below_x) : cur_r;

        job.wen      = first || (r_pos < r_area);
        job.px       = (i_kind == KIND_PIXEL) ? i_pixel : '0;
        job.wr_addr  = r_wr_addr;
        job.emit     = emit;
        job.last     = last;
        job.out_addr = r_out_addr;
        job.yoff     = yoff;
        job.xoff     = xoff;
        job.rows     = CW'(yoff) + CW'(ylow) + CW'(1);
        job.cols     = CW'(xoff) + CW'(xlow) + CW'(1);
        job.w        = cur_w;
    end

    assign o_job = job;

    // Position counters and the per-frame copy of the configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_delay    <= '0;
            r_area     <= '0;
            r_wr_addr  <= '0;
            r_out_addr <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_act_r    <= '0;
            r_act_w    <= '0;
            r_act_h    <= '0;
        end else if (accept) begin
            if (first) begin
                r_act_r <= sat_r;
                r_act_w <= sat_w;
                r_act_h <= sat_h;
                r_delay <= PW'(sat_r) * PW'(sat_w) + PW'(sat_r);
                r_area  <= PW'(sat_h) * PW'(sat_w);
            end
            if (last) begin
                r_pos      <= '0;
                r_wr_addr  <= '0;
                r_out_addr <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
            end else begin
                r_pos     <= r_pos + PW'(1);
                r_wr_addr <= (int'(r_wr_addr) == RING - 1) ? '0 : r_wr_addr + AW'(1);
                if (emit) begin
                    r_out_addr <= (int'(r_out_addr) == RING - 1) ? '0
                                                                  : r_out_addr + AW'(1);
                    if (r_out_col == cur_w - WW'(1)) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + HW'(1);
                    end else begin
                        r_out_col <= r_out_col + WW'(1);
                    end
                end
            end
        end
    end

endmodule

/* hdl/bbcw_back.sv */
// ============================================================================
// bbcw_back: pixel store, window summation and mean division
// Writes a job's pixel into the ring store when the job asks for it, then walks
// the clipped window one pixel a cycle and divides the three sums by the pixel count.
// ============================================================================
module bbcw_back #(
    parameter  int MAX_WIDTH  = 1024,
    parameter  int MAX_RADIUS = 15,
    localparam int WW    = $clog2(MAX_WIDTH + 1),
    localparam int RW    = $clog2(MAX_RADIUS + 1),
    localparam int CW    = $clog2(2 * MAX_RADIUS + 2),
    localparam int RING  = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1),
    localparam int AW    = $clog2(RING),
    localparam int NMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1),
    localparam int NW    = $clog2(NMAX + 1),
    localparam int SW    = $clog2(NMAX * 255 + 1),
    localparam int JOB_W = 3 + 24 + 2 * AW + 2 * RW + 2 * CW + WW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [23:0]      o_pixel,
    output logic             o_last
);
    import bbcw_pkg::*;

    typedef struct packed {
        logic              wen;
        logic [PIX_W-1:0]  px;
        logic [AW-1:0]     wr_addr;
        logic              emit;
        logic              last;
        logic [AW-1:0]     out_addr;
        logic [RW-1:0]     yoff;
        logic [RW-1:0]     xoff;
        logic [CW-1:0]     rows;
        logic [CW-1:0]     cols;
        logic [WW-1:0]     w;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_OFFS, S_BASE, S_READ, S_DRAIN, S_DIV, S_OUT
    } t_state;

    t_job             job;
    t_state           r_state;
    logic [PIX_W-1:0] r_mem [RING];
    logic [PIX_W-1:0] r_rd;
    logic             r_rd_vld;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_row_addr;
    logic [AW-1:0]    r_off;
    logic [NW-1:0]    r_cnt;
    logic [CW-1:0]    r_xi;
    logic [CW-1:0]    r_yi;
    logic [2:0]       r_bit;
    logic [SW-1:0]    r_sum [3];
    logic [CH_W-1:0]  r_q [3];
    logic             r_last;
    logic [AW-1:0]    r_out_addr;
    logic [RW-1:0]    r_yoff;
    logic [RW-1:0]    r_xoff;
    logic [CW-1:0]    r_rows;
    logic [CW-1:0]    r_cols;
    logic [WW-1:0]    r_w;

    logic             wen;
    logic [AW:0]      next_row;
    logic [AW:0]      dvs;
    logic [SW+7:0]    shifted;

    assign job   = i_job;
    assign o_pop = (r_state == S_IDLE) & i_valid;
    assign wen   = o_pop & job.wen;

    assign next_row = (AW+1)'(r_row_addr) + (AW+1)'(r_w);
    assign shifted  = (SW+8)'(r_cnt) << r_bit;
    assign dvs      = (AW+1)'(r_out_addr) + (AW+1)'(RING) - (AW+1)'(r_off);

    assign o_valid = (r_state == S_OUT);
    assign o_pixel = {r_q[2], r_q[1], r_q[0]};
    assign o_last  = r_last;

    // Ring store of recent pixels
    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[job.wr_addr] <= job.px;
        end
        r_rd <= r_mem[r_addr];
    end

    // Window walk, accumulation and division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
            if (r_rd_vld) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= r_sum[c] + SW'(r_rd[c*CH_W +: CH_W]);
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && job.emit) begin
                        r_last     <= job.last;
                        r_out_addr <= job.out_addr;
                        r_yoff     <= job.yoff;
                        r_xoff     <= job.xoff;
                        r_rows     <= job.rows;
                        r_cols     <= job.cols;
                        r_w        <= job.w;
                        r_state    <= S_OFFS;
                    end
                end
                S_OFFS: begin
                    r_off   <= AW'(AW'(r_yoff) * AW'(r_w)) + AW'(r_xoff);
                    r_cnt   <= NW'(NW'(r_rows) * NW'(r_cols));
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    // Step back to the window's top left corner, modulo the ring
                    if (r_out_addr >= r_off) begin
                        r_row_addr <= r_out_addr - r_off;
                        r_addr     <= r_out_addr - r_off;
                    end else begin
                        r_row_addr <= AW'(dvs);
                        r_addr     <= AW'(dvs);
                    end
                    r_xi  <= '0;
                    r_yi  <= '0;
                    r_bit <= 3'd7;
                    for (int c = 0; c < 3; c++) begin
                        r_sum[c] <= '0;
                        r_q[c]   <= '0;
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_xi == r_cols - CW'(1)) begin
                        r_xi <= '0;
                        if (r_yi == r_rows - CW'(1)) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_yi <= r_yi + CW'(1);
                            if (int'(next_row) >= RING) begin
                                r_row_addr <= AW'(next_row - (AW+1)'(RING));
                                r_addr     <= AW'(next_row - (AW+1)'(RING));
                            end else begin
                                r_row_addr <= AW'(next_row);
                                r_addr     <= AW'(next_row);
                            end
                        end
                    end else begin
                        r_xi   <= r_xi + CW'(1);
                        r_addr <= (int'(r_addr) == RING - 1) ? '0 : r_addr + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // One quotient bit per cycle, restoring division
                    for (int c = 0; c < 3; c++) begin
                        if ((SW+8)'(r_sum[c]) >= shifted) begin
                            r_sum[c]      <= r_sum[c] - SW'(shifted);
                            r_q[c][r_bit] <= 1'b1;
                        end
                    end
                    if (r_bit == 3'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/box_blur_clipped_window_top.sv */
// ============================================================================
// box_blur_clipped_window_top: streaming RGB box blur with clipped window
// Configuration registers, front end, job queue and window back end.
// ============================================================================
//  Channel  | Signals                         | Beat contents
//  ---------+---------------------------------+-------------------------------
//  in       | s_tvalid/s_tready/s_tdata/tuser | tuser kind, tdata r,g,b
//  out      | m_tvalid/m_tready/m_tdata/tlast | tdata r,g,b, tlast frame end
//  config   | psel/penable/pwrite/paddr/...   | radius 0x0, width 0x4, height 0x8
//
// A beat that makes no output is taken from the queue without a window walk.
// A beat that makes an output holds the back end while it reads the window
// one pixel a cycle from the ring store, which has one write and one read
// port, then divides the sums. The two-entry queue lets the input keep
// flowing while a result waits on m_tready. Reset is synchronous and clears
// all control state; the pixel store needs no clearing pass.
module box_blur_clipped_window_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out, green_out, blue_out
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bbcw_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int CW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int RING  = (2 * MAX_RADIUS + 1) * (MAX_WIDTH + 1);
    localparam int AW    = $clog2(RING);
    localparam int JOB_W = 3 + 24 + 2 * AW + 2 * RW + 2 * CW + WW;

    t_cfg             r_cfg;
    t_reg_idx         reg_idx;
    logic             cfg_wr;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic [JOB_W-1:0] f_job;
    logic [JOB_W-1:0] q_job;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius       <= RADIUS_RST;
            r_cfg.image_width  <= WIDTH_RST;
            r_cfg.image_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RADIUS: r_cfg.radius       <= pwdata[RADIUS_W-1:0];
                REG_WIDTH:  r_cfg.image_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_cfg.image_height <= pwdata[DIM_W-1:0];
                default:    r_cfg              <= r_cfg;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            REG_RADIUS: prdata = 32'(r_cfg.radius);
            REG_WIDTH:  prdata = 32'(r_cfg.image_width);
            REG_HEIGHT: prdata = 32'(r_cfg.image_height);
            default:    prdata = '0;
        endcase
    end

    bbcw_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_kind  (s_tuser),
        .i_pixel (s_tdata),
        .o_push  (push),
        .o_job   (f_job),
        .i_full  (q_full)
    );

    bbcw_queue #(
        .DW (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_job),
        .i_pop   (pop)
    );

    bbcw_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_job   (q_job),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_pixel (m_tdata),
        .o_last  (m_tlast)
    );

endmodule

/* hdl/bbcw_checker.sv */
// ============================================================================
// bbcw_checker: port-level checks of the box blur
// Watches the top level's ports over time; bound to the top level.
// ============================================================================
module bbcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        pready
);

    // A waiting result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat withdrawn while stalled");

    // A waiting result keeps its contents
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Nothing is offered straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // Each result needs a fresh window walk, so beats never come back to back
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("output beats in consecutive cycles");

    // The register port never inserts wait states
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind box_blur_clipped_window_top bbcw_checker u_bbcw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

/* tb/box_blur_clipped_window_top_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// box_blur_clipped_window_top_test: self-checking bench for the clipped blur
// Streams RGB frames through the blur with random gaps and stalls on both
// buses. Every output beat is compared with a local running model of the
// clipped-window mean. Frame shapes run from a single pixel to windows far
// larger than the frame at the largest radius.
// ============================================================================
module box_blur_clipped_window_top_test;
    import bbcw_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int MAX_R      = 15;
    localparam int RING       = (2 * MAX_R + 1) * (MAX_W + 1);
    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 800;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pix;

    // One row of the directed table; the expectation is used when typed is set
    typedef struct {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        t_pix       want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red_in, green_in, blue_in
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red_out, green_out, blue_out
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    box_blur_clipped_window_top dut (.*);

    // Local copy of the blur state
    logic [23:0]          pixel_ring [RING];
    int unsigned          in_col, in_row, out_col, out_row;
    int unsigned          act_r, act_w, act_h;
    logic [RADIUS_W-1:0]  reg_radius;
    logic [DIM_W-1:0]     reg_width;
    logic [DIM_W-1:0]     reg_height;
    t_pix                 pending_pix [$];
    int                   errors;
    int                   cycles;
    bit                   calm;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Clipped-window mean of one accepted beat; queues the output it causes
    function automatic void blur_step(logic kind, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b);
        int unsigned pos, dly, y0, y1, x0, x1, cnt, sr, sg, sb, y, x;
        logic [23:0] p;
        t_pix        e;
        if (in_row == 0 && in_col == 0) begin
            act_w = (reg_width == 0) ? 1 : reg_width;
            if (act_w > MAX_W) act_w = MAX_W;
            act_h = (reg_height == 0) ? 1 : reg_height;
            if (act_h > MAX_H) act_h = MAX_H;
            act_r = (reg_radius > MAX_R) ? MAX_R : reg_radius;
        end
        pos = in_row * act_w + in_col;
        if (in_row < act_h)
            pixel_ring[pos % RING] = (kind == KIND_PIXEL) ? {r, g, b} : 24'd0;
        in_col++;
        if (in_col >= act_w) begin
            in_col = 0;
            in_row++;
        end
        dly = act_r * act_w + act_r;
        if (pos < dly) return;
        y0 = (out_row > act_r) ? out_row - act_r : 0;
        y1 = (out_row + act_r < act_h) ? out_row + act_r : act_h - 1;
        x0 = (out_col > act_r) ? out_col - act_r : 0;
        x1 = (out_col + act_r < act_w) ? out_col + act_r : act_w - 1;
        cnt = (y1 - y0 + 1) * (x1 - x0 + 1);
        sr = 0;
        sg = 0;
        sb = 0;
        for (y = y0; y <= y1; y++) begin
            for (x = x0; x <= x1; x++) begin
                p = pixel_ring[(y * act_w + x) % RING];
                sr += p[23:16];
                sg += p[15:8];
                sb += p[7:0];
            end
        end
        e.red   = 8'(sr / cnt);
        e.green = 8'(sg / cnt);
        e.blue  = 8'(sb / cnt);
        e.last  = (out_row == act_h - 1) && (out_col == act_w - 1);
        pending_pix.push_back(e);
        if (e.last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= act_w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // Register write: setup cycle, then access cycle
    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RADIUS: reg_radius = val[RADIUS_W-1:0];
            REG_WIDTH:  reg_width  = val[DIM_W-1:0];
            REG_HEIGHT: reg_height = val[DIM_W-1:0];
            default: ;
        endcase
    endtask

    // New frame shape, written once every awaited output has come back
    task automatic set_frame(int r, int w, int h);
        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        reg_write(REG_RADIUS, r);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    // One input beat, with an optional random gap ahead of it
    task automatic send_beat(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!calm && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!s_tready);
        blur_step(kind, r, g, b);
    endtask

    // Random frame in the current shape: pixels, then drain beats
    task automatic send_frame(int r, int w, int h, inout int sent);
        int n, tot, k;
        int unsigned rr, ww, hh;
        ww  = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
        hh  = (h == 0) ? 1 : ((h > MAX_H) ? MAX_H : h);
        rr  = r;
        n   = ww * hh;
        tot = n + rr * ww + rr;
        for (k = 0; k < tot; k++) begin
            calm = (sent >= 300 && sent < 450);
            if (k < n)
                send_beat(($urandom_range(99) < 8) ? KIND_DRAIN : KIND_PIXEL,
                          8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_beat(($urandom_range(99) < 80) ? KIND_DRAIN : KIND_PIXEL,
                          8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
        end
    endtask

    // Output side: random stalls, each beat checked against the oldest expectation
    always @(posedge i_clk) begin
        t_pix e;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_pix.size() == 0) begin
                    $error("output beat with nothing expected: tdata %h", m_tdata);
                    errors++;
                end else begin
                    e = pending_pix.pop_front();
                    if (m_tdata[7:0] !== e.red) begin
                        $error("red_out: expected %0d, got %0d", e.red, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[15:8] !== e.green) begin
                        $error("green_out: expected %0d, got %0d", e.green, m_tdata[15:8]);
                        errors++;
                    end
                    if (m_tdata[23:16] !== e.blue) begin
                        $error("blue_out: expected %0d, got %0d", e.blue, m_tdata[23:16]);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("frame_end: expected %0d, got %0d", e.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 37);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("box_blur_clipped_window_top_test: done, errors");
            $finish;
        end
    end

    initial begin
        t_row table_rows [21];
        int   i, sent, f, r, w, h;
        t_pix e;

        // Radius 0, 4x2: outputs equal inputs, drain inside the frame is black
        table_rows[0]  = '{KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1, '{8'h00, 8'h00, 8'h00, 0}};
        table_rows[1]  = '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, '{8'hFF, 8'hFF, 8'hFF, 0}};
        table_rows[2]  = '{KIND_PIXEL, 8'h12, 8'h34, 8'h56, 1, '{8'h12, 8'h34, 8'h56, 0}};
        table_rows[3]  = '{KIND_DRAIN, 8'hAA, 8'hBB, 8'hCC, 1, '{8'h00, 8'h00, 8'h00, 0}};
        table_rows[4]  = '{KIND_PIXEL, 8'h80, 8'h7F, 8'h01, 1, '{8'h80, 8'h7F, 8'h01, 0}};
        table_rows[5]  = '{KIND_PIXEL, 8'h55, 8'hAA, 8'h0F, 1, '{8'h55, 8'hAA, 8'h0F, 0}};
        table_rows[6]  = '{KIND_PIXEL, 8'hF0, 8'h0F, 8'h3C, 1, '{8'hF0, 8'h0F, 8'h3C, 0}};
        table_rows[7]  = '{KIND_PIXEL, 8'h01, 8'h02, 8'h03, 1, '{8'h01, 8'h02, 8'h03, 1}};
        // Radius 1, 3x3: clipped corners and edges, a black drain pixel,
        // then four beats past the frame: three drain beats and a pixel
        table_rows[8]  = '{KIND_PIXEL, 8'hFF, 8'h00, 8'h80, 0, '{0, 0, 0, 0}};
        table_rows[9]  = '{KIND_PIXEL, 8'hFE, 8'h01, 8'h7F, 0, '{0, 0, 0, 0}};
        table_rows[10] = '{KIND_PIXEL, 8'hFD, 8'h10, 8'h40, 0, '{0, 0, 0, 0}};
        table_rows[11] = '{KIND_PIXEL, 8'h00, 8'hFF, 8'h20, 0, '{0, 0, 0, 0}};
        table_rows[12] = '{KIND_DRAIN, 8'h99, 8'h99, 8'h99, 0, '{0, 0, 0, 0}};
        table_rows[13] = '{KIND_PIXEL, 8'h33, 8'hC0, 8'hFF, 0, '{0, 0, 0, 0}};
        table_rows[14] = '{KIND_PIXEL, 8'h07, 8'h70, 8'hEE, 0, '{0, 0, 0, 0}};
        table_rows[15] = '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '{0, 0, 0, 0}};
        table_rows[16] = '{KIND_PIXEL, 8'h5A, 8'hA5, 8'h00, 0, '{0, 0, 0, 0}};
        table_rows[17] = '{KIND_DRAIN, 8'h00, 8'h00, 8'h00, 0, '{0, 0, 0, 0}};
        table_rows[18] = '{KIND_DRAIN, 8'hFF, 8'hFF, 8'hFF, 0, '{0, 0, 0, 0}};
        table_rows[19] = '{KIND_DRAIN, 8'h00, 8'h00, 8'h00, 0, '{0, 0, 0, 0}};
        table_rows[20] = '{KIND_PIXEL, 8'hC3, 8'h3C, 8'h81, 0, '{0, 0, 0, 0}};

        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_PIXEL;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors   = 0;
        cycles   = 0;
        calm     = 1'b0;
        in_col   = 0;
        in_row   = 0;
        out_col  = 0;
        out_row  = 0;
        reg_radius = RADIUS_RST;
        reg_width  = WIDTH_RST;
        reg_height = HEIGHT_RST;
        for (i = 0; i < RING; i++) pixel_ring[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        set_frame(0, 4, 2);
        for (i = 0; i < 21; i++) begin
            if (i == 8) begin
                s_tvalid <= 1'b0;
                set_frame(1, 3, 3);
            end
            send_beat(table_rows[i].kind, table_rows[i].red, table_rows[i].green,
                      table_rows[i].blue);
            if (table_rows[i].typed) begin
                e = pending_pix.pop_back();
                pending_pix.push_back(table_rows[i].want);
            end
        end
        s_tvalid <= 1'b0;

        // Extreme shapes first, then mostly small random frames
        sent = 0;
        f = 0;
        while (sent < RAND_ITEMS) begin
            case (f)
                0: begin r = 15; w = 1;    h = 24;   end
                1: begin r = 15; w = 0;    h = 0;    end
                2: begin r = 4;  w = 9;    h = 9;    end
                3: begin r = 15; w = 3;    h = 2;    end
                default: begin
                    r = $urandom_range(0, 3);
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 7);
                end
            endcase
            s_tvalid <= 1'b0;
            set_frame(r, w, h);
            send_frame(r, w, h, sent);
            f++;
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_pix.size() != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        if (errors == 0) begin
            $display("box_blur_clipped_window_top_test: done, clean");
        end else begin
            $display("box_blur_clipped_window_top_test: done, errors");
        end
        $finish;
    end

endmodule
